### hdl/tec_pkg.sv
// Shared types, constants and register codes of the tricorn escape-time core.
package tec_pkg;

   localparam int DEF_WIDTH = 640;
   localparam int DEF_HEIGHT = 480;

   localparam int FRAC_BITS = 28;
   localparam int COORD_W = 10;
   localparam int DELTA_W = COORD_W + 1;
   localparam int FIX_W = 32;
   localparam int STEP_W = 31;
   localparam int COUNT_W = 16;
   localparam int PROD_W = 2 * FIX_W;
   localparam int SQ_W = PROD_W - FRAC_BITS;
   localparam int MAG_W = SQ_W + 1;
   localparam int CSR_INDEX_W = 3;

   localparam logic [MAG_W-1:0] ESC_LIMIT = MAG_W'(4) << FRAC_BITS;

   localparam logic [FIX_W-1:0] RST_CENTER_RE = '0;
   localparam logic [FIX_W-1:0] RST_CENTER_IM = '0;
   localparam logic [STEP_W-1:0] RST_PIXEL_STEP = STEP_W'(1398101);
   localparam logic [FIX_W-1:0] RST_OFFSET_RE = '0;
   localparam logic [FIX_W-1:0] RST_OFFSET_IM = '0;
   localparam logic [COUNT_W-1:0] RST_MAX_ITER = COUNT_W'(50);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CENTER_RE = 3'd0,
      REG_CENTER_IM = 3'd1,
      REG_PIXEL_STEP = 3'd2,
      REG_OFFSET_RE = 3'd3,
      REG_OFFSET_IM = 3'd4,
      REG_MAX_ITER = 3'd5
   } reg_index_type;

   typedef logic [2:0] step_type;
   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_MAP_X = 3'd1;
   localparam step_type STEP_MAP_Y = 3'd2;
   localparam step_type STEP_INIT = 3'd3;
   localparam step_type STEP_LOOP = 3'd4;
   localparam step_type STEP_UPDATE = 3'd5;
   localparam step_type STEP_DONE = 3'd6;

   typedef enum logic [2:0] {
      COND_NEVER = 3'd0,
      COND_REQ_IDLE = 3'd1,
      COND_LIMIT = 3'd2,
      COND_ESCAPE = 3'd3,
      COND_RSP_BUSY = 3'd4
   } cond_type;

   typedef enum logic [1:0] {
      MUL_ITER = 2'd0,
      MUL_MAP_X = 2'd1,
      MUL_MAP_Y = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic accept;
      mul_sel_type mul_sel;
      logic load_prod;
      logic load_cre;
      logic load_cim;
      logic init_z;
      logic update;
      logic emit;
      cond_type cond;
      step_type target_t;
      step_type target_f;
   } ctl_type;

   typedef struct packed {
      logic [FIX_W-1:0] center_re;
      logic [FIX_W-1:0] center_im;
      logic [STEP_W-1:0] pixel_step;
      logic [FIX_W-1:0] offset_re;
      logic [FIX_W-1:0] offset_im;
      logic [COUNT_W-1:0] max_iter;
   } cfg_type;

   typedef struct packed {
      logic limit;
      logic escape;
      logic [COUNT_W-1:0] count;
   } stat_type;

endpackage

### hdl/tec_if.sv
// Valid/ready channel interfaces for pixel requests and escape-time responses.
interface tec_req_if import tec_pkg::*; ();
   logic valid;
   logic ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tec_rsp_if import tec_pkg::*; ();
   logic valid;
   logic ready;
   logic [COUNT_W-1:0] iteration_count;
   logic inside_set;

   modport source (output valid, output iteration_count, output inside_set, input ready);
   modport sink (input valid, input iteration_count, input inside_set, output ready);
endinterface

### hdl/tec_rom.sv
// Control store: one control word per sequencer step.
module tec_rom import tec_pkg::*; (
   input step_type pc,
   output ctl_type ctl
);

   always_comb begin
      ctl = '{accept: 1'b0, mul_sel: MUL_ITER, load_prod: 1'b0, load_cre: 1'b0,
              load_cim: 1'b0, init_z: 1'b0, update: 1'b0, emit: 1'b0,
              cond: COND_NEVER, target_t: STEP_IDLE, target_f: STEP_IDLE};
      case (pc)
         STEP_IDLE: begin
            ctl.accept = 1'b1;
            ctl.cond = COND_REQ_IDLE;
            ctl.target_t = STEP_IDLE;
            ctl.target_f = STEP_MAP_X;
         end
         STEP_MAP_X: begin
            ctl.mul_sel = MUL_MAP_X;
            ctl.load_prod = 1'b1;
            ctl.target_f = STEP_MAP_Y;
         end
         STEP_MAP_Y: begin
            ctl.mul_sel = MUL_MAP_Y;
            ctl.load_prod = 1'b1;
            ctl.load_cre = 1'b1;
            ctl.target_f = STEP_INIT;
         end
         STEP_INIT: begin
            ctl.load_cim = 1'b1;
            ctl.init_z = 1'b1;
            ctl.target_f = STEP_LOOP;
         end
         STEP_LOOP: begin
            ctl.mul_sel = MUL_ITER;
            ctl.load_prod = 1'b1;
            ctl.cond = COND_LIMIT;
            ctl.target_t = STEP_DONE;
            ctl.target_f = STEP_UPDATE;
         end
         STEP_UPDATE: begin
            ctl.update = 1'b1;
            ctl.cond = COND_ESCAPE;
            ctl.target_t = STEP_DONE;
            ctl.target_f = STEP_LOOP;
         end
         STEP_DONE: begin
            ctl.emit = 1'b1;
            ctl.cond = COND_RSP_BUSY;
            ctl.target_t = STEP_DONE;
            ctl.target_f = STEP_IDLE;
         end
         default: begin
            ctl.target_f = STEP_IDLE;
         end
      endcase
   end

endmodule

### hdl/tec_datapath.sv
// Datapath: pixel mapping, three multipliers, z and count registers.
module tec_datapath import tec_pkg::*; #(
   parameter int WIDTH = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT
) (
   input logic clock,
   input ctl_type ctl,
   input cfg_type cfg,
   input logic pix_load,
   input logic [COORD_W-1:0] pixel_x,
   input logic [COORD_W-1:0] pixel_y,
   output stat_type stat
);

   localparam logic [DELTA_W-1:0] HALF_X = DELTA_W'(WIDTH / 2);
   localparam logic [DELTA_W-1:0] HALF_Y = DELTA_W'(HEIGHT / 2);

   logic [COORD_W-1:0] px_ff, py_ff;
   logic [DELTA_W-1:0] dx, dy;
   logic [FIX_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] prod0, prod1, prod2;
   logic [PROD_W-1:0] p0_ff, p0_in;
   logic [SQ_W-1:0] p1_ff, p1_in;
   logic [FIX_W-1:0] p2_ff, p2_in;
   logic [FIX_W-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic [FIX_W-1:0] z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [MAG_W-1:0] mag;
   logic escape;

   assign dx = {1'b0, px_ff} - HALF_X;
   assign dy = {1'b0, py_ff} - HALF_Y;

   always_comb begin
      case (ctl.mul_sel)
         MUL_MAP_X: begin
            mul_a = {{(FIX_W-DELTA_W){dx[DELTA_W-1]}}, dx};
            mul_b = {1'b0, cfg.pixel_step};
         end
         MUL_MAP_Y: begin
            mul_a = {{(FIX_W-DELTA_W){dy[DELTA_W-1]}}, dy};
            mul_b = {1'b0, cfg.pixel_step};
         end
         default: begin
            mul_a = z_re_ff;
            mul_b = z_re_ff;
         end
      endcase
   end

   assign prod0 = $signed(mul_a) * $signed(mul_b);
   assign prod1 = $signed(z_im_ff) * $signed(z_im_ff);
   assign prod2 = $signed(z_re_ff) * $signed(z_im_ff);

   assign p0_in = ctl.load_prod ? prod0 : p0_ff;
   assign p1_in = ctl.load_prod ? prod1[PROD_W-1:FRAC_BITS] : p1_ff;
   assign p2_in = ctl.load_prod ? prod2[FIX_W+FRAC_BITS-2:FRAC_BITS-1] : p2_ff;

   assign mag = {1'b0, p0_ff[PROD_W-1:FRAC_BITS]} + {1'b0, p1_ff};
   assign escape = mag > ESC_LIMIT;

   assign c_re_in = ctl.load_cre ? cfg.center_re + p0_ff[FIX_W-1:0] + cfg.offset_re : c_re_ff;
   assign c_im_in = ctl.load_cim ? cfg.center_im + p0_ff[FIX_W-1:0] + cfg.offset_im : c_im_ff;

   always_comb begin
      z_re_in = z_re_ff;
      z_im_in = z_im_ff;
      count_in = count_ff;
      if (ctl.init_z) begin
         z_re_in = '0;
         z_im_in = '0;
         count_in = '0;
      end else if (ctl.update) begin
         z_re_in = p0_ff[FIX_W+FRAC_BITS-1:FRAC_BITS] - p1_ff[FIX_W-1:0] + c_re_ff;
         z_im_in = c_im_ff - p2_ff;
         if (!escape) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_load) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      c_re_ff <= c_re_in;
      c_im_ff <= c_im_in;
      z_re_ff <= z_re_in;
      z_im_ff <= z_im_in;
      count_ff <= count_in;
   end

   assign stat.limit = count_ff >= cfg.max_iter;
   assign stat.escape = escape;
   assign stat.count = count_ff;

endmodule

### hdl/tricorn_escape_time_core.sv
// Tricorn escape-time core: maps a pixel to c and counts iterations of
// z <- conj(z)^2 + c until |z|^2 exceeds 4 or the limit is met. A step counter
// walks a seven-word control store; each iteration runs a loop step, which
// forms the three 32x32 products into registers, and an update step, which
// updates z, tests the escape and counts. The done step holds while the result
// register still waits for a previous word to be taken. The next pixel is
// accepted while a result waits.
module tricorn_escape_time_core import tec_pkg::*; #(
   parameter int WIDTH = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT
) (
   input logic clock,
   input logic reset,
   tec_req_if.sink req,
   tec_rsp_if.source rsp,
   input logic csr_write_en,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [FIX_W-1:0] csr_wdata
);

   step_type pc_ff, pc_in;
   ctl_type ctl;
   stat_type stat;
   cfg_type cfg_ff, cfg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_inside_ff, rsp_inside_in;
   logic rsp_busy, cond_true, emit_fire;

   tec_rom u_rom (
      .pc (pc_ff),
      .ctl (ctl)
   );

   tec_datapath #(
      .WIDTH (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_datapath (
      .clock (clock),
      .ctl (ctl),
      .cfg (cfg_ff),
      .pix_load (req.valid && ctl.accept),
      .pixel_x (req.pixel_x),
      .pixel_y (req.pixel_y),
      .stat (stat)
   );

   assign rsp_busy = rsp_valid_ff && !rsp.ready;

   always_comb begin
      case (ctl.cond)
         COND_REQ_IDLE: cond_true = !req.valid;
         COND_LIMIT: cond_true = stat.limit;
         COND_ESCAPE: cond_true = stat.escape;
         COND_RSP_BUSY: cond_true = rsp_busy;
         default: cond_true = 1'b0;
      endcase
   end

   assign pc_in = cond_true ? ctl.target_t : ctl.target_f;
   assign emit_fire = ctl.emit && !rsp_busy;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = stat.count;
         rsp_inside_in = stat.limit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_CENTER_RE: cfg_in.center_re = csr_wdata;
            REG_CENTER_IM: cfg_in.center_im = csr_wdata;
            REG_PIXEL_STEP: cfg_in.pixel_step = csr_wdata[STEP_W-1:0];
            REG_OFFSET_RE: cfg_in.offset_re = csr_wdata;
            REG_OFFSET_IM: cfg_in.offset_im = csr_wdata;
            REG_MAX_ITER: cfg_in.max_iter = csr_wdata[COUNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff <= '{center_re: RST_CENTER_RE, center_im: RST_CENTER_IM,
                     pixel_step: RST_PIXEL_STEP, offset_re: RST_OFFSET_RE,
                     offset_im: RST_OFFSET_IM, max_iter: RST_MAX_ITER};
      end else begin
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff <= cfg_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign req.ready = ctl.accept;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.iteration_count = rsp_count_ff;
   assign rsp.inside_set = rsp_inside_ff;

endmodule
